### sv/julian_day_to_calendar_date_defines.svh
// Shared assertion macros for the Julian day to calendar date block.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH

// Checks that a condition holds in the same cycle whenever the enable holds.
`define JDCD_CHECK(label, en, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |-> (cond)) \
        else $error(msg);

// Checks that a condition holds in the cycle after the enable holds.
`define JDCD_CHECK_NEXT(label, en, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |=> (cond)) \
        else $error(msg);

`endif

### sv/jdcd_pkg.sv
package jdcd_pkg;

    localparam int JDCD_NST = 11;

    typedef logic [JDCD_NST-1:0] t_stage_vec;

    typedef struct packed {
        t_stage_vec adv;
        t_stage_vec vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] milli;
    } t_tod_res;

endpackage

### sv/julian_day_to_calendar_date.sv
// Throughput: one request per cycle while the output is not stalled, set by the
// eleven-stage pipeline in which the Gregorian and year divisions each take a
// multiply, a back-multiply and a correction stage; months use a compare stage.
// A stalled output holds the pipeline, and empty stages still fill while it waits.
// Reset (synchronous, active low) clears only the stage valid bits.
`include "julian_day_to_calendar_date_defines.svh"

module julian_day_to_calendar_date import jdcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // julian_day_number [22:0], day_fraction_ms [49:23], zero fill [55:50]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cal_year [14:0], cal_month [18:15], cal_day [23:19], hour_of_day [28:24],
    // minute_of_hour [34:29], second_of_minute [40:35], milli_of_second [50:41],
    // zero fill [55:51]
    output logic [55:0] m_axis_tdata
);

    localparam logic [22:0] GREG_START  = 23'd2299161;
    localparam logic [22:0] GREG_BASE   = 23'd1867216;
    localparam logic [24:0] GREG_DIV    = 25'd146097;
    localparam logic [7:0]  RECIP_GREG  = 8'd229;
    localparam logic [23:0] DAY_OFFSET  = 24'd1524;
    localparam logic [29:0] YEAR_BIAS   = 30'd12210;
    localparam logic [29:0] YEAR_DIV    = 30'd36525;
    localparam logic [14:0] RECIP_YEAR  = 15'd29397;
    localparam logic [25:0] QDAYS_4Y    = 26'd1461;
    localparam logic [22:0] MONTH_DIV   = 23'd306001;
    localparam logic [22:0] MONTH_SCALE = 23'd10000;
    localparam logic signed [16:0] YEAR_BASE = 17'sd4715;
    localparam logic [8:0]  DAYS_BEFORE [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    t_stage_vec  r_vld;
    t_stage_vec  n_rdy;
    t_pipe_ctl   n_ctl;
    logic        w_carry;
    t_tod_res    w_tod;

    logic [22:0] n_jdn;
    logic        n_greg;
    logic [24:0] n_xt;
    logic [32:0] n_pt;
    logic [24:0] n_td, n_rt;
    logic [7:0]  n_t, n_corr;
    logic [23:0] n_j2;
    logic [29:0] n_x3;
    logic [44:0] n_p3;
    logic [29:0] n_yd, n_r3;
    logic [25:0] n_p4;
    logic [23:0] n_e;
    logic [22:0] n_e10k;
    logic [3:0]  n_j5;
    logic [8:0]  n_d;
    logic [3:0]  n_m0, n_m;
    logic signed [16:0] n_y, n_ya;

    logic [22:0] r_s0_jdn;
    logic        r_s0_greg;
    logic [24:0] r_s0_xt;
    logic [22:0] r_s1_jdn;
    logic        r_s1_greg;
    logic        r_s1_carry;
    logic [24:0] r_s1_xt;
    logic [7:0]  r_s1_qt;
    logic [22:0] r_s2_jdn;
    logic        r_s2_greg;
    logic        r_s2_carry;
    logic [7:0]  r_s2_qt;
    logic [18:0] r_s2_rt;
    logic [23:0] r_s3_j2;
    logic [23:0] r_s4_j2;
    logic [29:0] r_s4_x3;
    logic [23:0] r_s5_j2;
    logic [29:0] r_s5_x3;
    logic [14:0] r_s5_q;
    logic [23:0] r_s6_j2;
    logic [14:0] r_s6_q;
    logic [16:0] r_s6_r;
    logic [23:0] r_s7_j2;
    logic [14:0] r_s7_j3;
    logic [14:0] r_s8_j3;
    logic [8:0]  r_s8_e;
    logic [14:0] r_s9_j3;
    logic [8:0]  r_s9_e;
    logic [3:0]  r_s9_j5;
    logic [14:0] r_s10_year;
    logic [3:0]  r_s10_month;
    logic [4:0]  r_s10_day;

    always_comb begin
        for (int k = 0; k < JDCD_NST; k++) begin
            n_rdy[k] = m_axis_tready || (|(~r_vld & (t_stage_vec'('1) << k)));
        end
        n_ctl.adv = n_rdy;
        n_ctl.vld = r_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < JDCD_NST; k++) begin
                if (n_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    jdcd_tod u_tod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (n_ctl),
        .i_fraction (s_axis_tdata[49:23]),
        .o_carry    (w_carry),
        .o_res      (w_tod)
    );

    always_comb begin
        n_jdn  = s_axis_tdata[22:0];
        n_greg = (n_jdn >= GREG_START);
        n_xt   = {n_jdn - GREG_BASE, 2'b00} - 25'd1;

        n_pt = 33'(r_s0_xt) * 33'(RECIP_GREG);

        n_td = 25'(r_s1_qt) * GREG_DIV;
        n_rt = r_s1_xt - n_td;

        n_t    = r_s2_qt + 8'(r_s2_rt >= GREG_DIV[18:0]);
        n_corr = r_s2_greg ? (8'd1 + n_t - {2'b00, n_t[7:2]}) : 8'd0;
        n_j2   = 24'(r_s2_jdn) + DAY_OFFSET + 24'(n_corr) + 24'(r_s2_carry);

        n_x3 = 30'(r_s3_j2) * 30'd100 - YEAR_BIAS;

        n_p3 = 45'(r_s4_x3) * 45'(RECIP_YEAR);

        n_yd = 30'(r_s5_q) * YEAR_DIV;
        n_r3 = r_s5_x3 - n_yd;

        n_p4 = 26'(r_s7_j3) * QDAYS_4Y;
        n_e  = r_s7_j2 - n_p4[25:2];

        n_e10k = 23'(r_s8_e) * MONTH_SCALE;
        n_j5   = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (n_e10k >= 23'(MONTH_DIV * 23'(k))) begin
                n_j5 = 4'(k);
            end
        end

        n_d  = r_s9_e - DAYS_BEFORE[r_s9_j5];
        n_m0 = r_s9_j5 - 4'd1;
        n_m  = (n_m0 > 4'd12) ? (n_m0 - 4'd12) : n_m0;
        n_y  = $signed({2'b00, r_s9_j3}) - YEAR_BASE - $signed({16'd0, n_m > 4'd2});
        n_ya = (n_y <= 17'sd0) ? (17'sd1 - n_y) : n_y;
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy[0]) begin
            r_s0_jdn  <= n_jdn;
            r_s0_greg <= n_greg;
            r_s0_xt   <= n_xt;
        end
        if (n_rdy[1]) begin
            r_s1_jdn   <= r_s0_jdn;
            r_s1_greg  <= r_s0_greg;
            r_s1_carry <= w_carry;
            r_s1_xt    <= r_s0_xt;
            r_s1_qt    <= n_pt[32:25];
        end
        if (n_rdy[2]) begin
            r_s2_jdn   <= r_s1_jdn;
            r_s2_greg  <= r_s1_greg;
            r_s2_carry <= r_s1_carry;
            r_s2_qt    <= r_s1_qt;
            r_s2_rt    <= n_rt[18:0];
        end
        if (n_rdy[3]) begin
            r_s3_j2 <= n_j2;
        end
        if (n_rdy[4]) begin
            r_s4_j2 <= r_s3_j2;
            r_s4_x3 <= n_x3;
        end
        if (n_rdy[5]) begin
            r_s5_j2 <= r_s4_j2;
            r_s5_x3 <= r_s4_x3;
            r_s5_q  <= n_p3[44:30];
        end
        if (n_rdy[6]) begin
            r_s6_j2 <= r_s5_j2;
            r_s6_q  <= r_s5_q;
            r_s6_r  <= n_r3[16:0];
        end
        if (n_rdy[7]) begin
            r_s7_j2 <= r_s6_j2;
            r_s7_j3 <= r_s6_q + 15'(r_s6_r >= YEAR_DIV[16:0]);
        end
        if (n_rdy[8]) begin
            r_s8_j3 <= r_s7_j3;
            r_s8_e  <= n_e[8:0];
        end
        if (n_rdy[9]) begin
            r_s9_j3 <= r_s8_j3;
            r_s9_e  <= r_s8_e;
            r_s9_j5 <= n_j5;
        end
        if (n_rdy[10]) begin
            r_s10_year  <= n_ya[14:0];
            r_s10_month <= n_m;
            r_s10_day   <= n_d[4:0];
        end
    end

    assign s_axis_tready = n_rdy[0];
    assign m_axis_tvalid = r_vld[JDCD_NST-1];
    assign m_axis_tdata  = {5'd0, w_tod.milli, w_tod.second, w_tod.minute, w_tod.hour,
                            r_s10_day, r_s10_month, r_s10_year};

    `JDCD_CHECK_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, r_vld[0], "accepted request did not enter the pipeline")
    `JDCD_CHECK(a_rem_range, r_vld[8], (r_s8_e >= 9'd123) && (r_s8_e <= 9'd488), "day remainder out of range")
    `JDCD_CHECK(a_month_range, m_axis_tvalid, (r_s10_month >= 4'd1) && (r_s10_month <= 4'd12), "month out of range")
    `JDCD_CHECK(a_day_range, m_axis_tvalid, (r_s10_day >= 5'd1) && (r_s10_day <= 5'd31), "day out of range")

endmodule

### sv/jdcd_tod.sv
`include "julian_day_to_calendar_date_defines.svh"

module jdcd_tod import jdcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctl   i_ctl,
    input  logic [26:0] i_fraction,
    output logic        o_carry,
    output t_tod_res    o_res
);

    localparam logic [26:0] FRAC_MAX     = 27'd86399999;
    localparam logic [26:0] MS_HALF_DAY  = 27'd43200000;
    localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
    localparam logic [26:0] MS_PER_HOUR  = 27'd3600000;
    localparam logic [21:0] MS_PER_MIN   = 22'd60000;
    localparam logic [15:0] MS_PER_SEC   = 16'd1000;
    localparam logic [5:0]  RECIP_HOUR   = 6'd37;
    localparam logic [6:0]  RECIP_MIN    = 7'd69;
    localparam logic [6:0]  RECIP_SEC    = 7'd65;

    logic [26:0] n_fr, n_sum, n_tod;
    logic        n_carry;
    logic [32:0] n_ph;
    logic [26:0] n_hd, n_rh;
    logic        n_hc;
    logic [22:0] n_hrem;
    logic [28:0] n_pm;
    logic [21:0] n_md, n_rm;
    logic        n_mc;
    logic [16:0] n_mrem;
    logic [22:0] n_ps;
    logic [15:0] n_sd, n_rs;
    logic        n_sc;
    logic [10:0] n_srem;

    logic [26:0] r_s0_tod;
    logic        r_s0_carry;
    logic [26:0] r_s1_tod;
    logic [4:0]  r_s1_q;
    logic [4:0]  r_s2_q;
    logic [22:0] r_s2_r;
    logic [4:0]  r_s3_hour;
    logic [21:0] r_s3_rem;
    logic [4:0]  r_s4_hour;
    logic [21:0] r_s4_rem;
    logic [5:0]  r_s4_q;
    logic [4:0]  r_s5_hour;
    logic [5:0]  r_s5_q;
    logic [16:0] r_s5_r;
    logic [4:0]  r_s6_hour;
    logic [5:0]  r_s6_min;
    logic [15:0] r_s6_rem;
    logic [4:0]  r_s7_hour;
    logic [5:0]  r_s7_min;
    logic [15:0] r_s7_rem;
    logic [5:0]  r_s7_q;
    logic [4:0]  r_s8_hour;
    logic [5:0]  r_s8_min;
    logic [5:0]  r_s8_q;
    logic [10:0] r_s8_r;
    t_tod_res    r_s9_res;
    t_tod_res    r_s10_res;

    always_comb begin
        n_fr    = (i_fraction > FRAC_MAX) ? FRAC_MAX : i_fraction;
        n_sum   = n_fr + MS_HALF_DAY;
        n_carry = (n_sum >= MS_PER_DAY);
        n_tod   = n_carry ? (n_sum - MS_PER_DAY) : n_sum;

        n_ph = 33'(r_s0_tod) * 33'(RECIP_HOUR);

        n_hd = 27'(r_s1_q) * MS_PER_HOUR;
        n_rh = r_s1_tod - n_hd;

        n_hc   = (r_s2_r >= MS_PER_HOUR[22:0]);
        n_hrem = n_hc ? (r_s2_r - MS_PER_HOUR[22:0]) : r_s2_r;

        n_pm = 29'(r_s3_rem) * 29'(RECIP_MIN);

        n_md = 22'(r_s4_q) * MS_PER_MIN;
        n_rm = r_s4_rem - n_md;

        n_mc   = (r_s5_r >= MS_PER_MIN[16:0]);
        n_mrem = n_mc ? (r_s5_r - MS_PER_MIN[16:0]) : r_s5_r;

        n_ps = 23'(r_s6_rem) * 23'(RECIP_SEC);

        n_sd = 16'(r_s7_q) * MS_PER_SEC;
        n_rs = r_s7_rem - n_sd;

        n_sc   = (r_s8_r >= MS_PER_SEC[10:0]);
        n_srem = n_sc ? (r_s8_r - MS_PER_SEC[10:0]) : r_s8_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_s0_tod   <= n_tod;
            r_s0_carry <= n_carry;
        end
        if (i_ctl.adv[1]) begin
            r_s1_tod <= r_s0_tod;
            r_s1_q   <= n_ph[31:27];
        end
        if (i_ctl.adv[2]) begin
            r_s2_q <= r_s1_q;
            r_s2_r <= n_rh[22:0];
        end
        if (i_ctl.adv[3]) begin
            r_s3_hour <= r_s2_q + 5'(n_hc);
            r_s3_rem  <= n_hrem[21:0];
        end
        if (i_ctl.adv[4]) begin
            r_s4_hour <= r_s3_hour;
            r_s4_rem  <= r_s3_rem;
            r_s4_q    <= n_pm[27:22];
        end
        if (i_ctl.adv[5]) begin
            r_s5_hour <= r_s4_hour;
            r_s5_q    <= r_s4_q;
            r_s5_r    <= n_rm[16:0];
        end
        if (i_ctl.adv[6]) begin
            r_s6_hour <= r_s5_hour;
            r_s6_min  <= r_s5_q + 6'(n_mc);
            r_s6_rem  <= n_mrem[15:0];
        end
        if (i_ctl.adv[7]) begin
            r_s7_hour <= r_s6_hour;
            r_s7_min  <= r_s6_min;
            r_s7_rem  <= r_s6_rem;
            r_s7_q    <= n_ps[21:16];
        end
        if (i_ctl.adv[8]) begin
            r_s8_hour <= r_s7_hour;
            r_s8_min  <= r_s7_min;
            r_s8_q    <= r_s7_q;
            r_s8_r    <= n_rs[10:0];
        end
        if (i_ctl.adv[9]) begin
            r_s9_res.hour   <= r_s8_hour;
            r_s9_res.minute <= r_s8_min;
            r_s9_res.second <= r_s8_q + 6'(n_sc);
            r_s9_res.milli  <= n_srem[9:0];
        end
        if (i_ctl.adv[10]) begin
            r_s10_res <= r_s9_res;
        end
    end

    assign o_carry = r_s0_carry;
    assign o_res   = r_s10_res;

    `JDCD_CHECK(a_hour_range, i_ctl.vld[3], r_s3_hour <= 5'd23, "hour out of range")
    `JDCD_CHECK(a_minute_range, i_ctl.vld[6], r_s6_min <= 6'd59, "minute out of range")
    `JDCD_CHECK(a_second_range, i_ctl.vld[9], (r_s9_res.second <= 6'd59) && (r_s9_res.milli <= 10'd999), "second or millisecond out of range")

endmodule

### tb/sv/julian_day_to_calendar_date_tb.sv
`timescale 1ns / 100ps

typedef struct {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  milli;
} t_cal_time;

class calendar_scoreboard;
    localparam longint MS_PER_DAY = 86400000;
    localparam longint MS_HALF_DAY = 43200000;
    localparam longint GREGORIAN_START = 2299161;

    t_cal_time expected_q[$];
    int        n_requests;
    int        n_results;
    int        n_errors;

    function new();
        n_requests = 0;
        n_results = 0;
        n_errors = 0;
    endfunction

    function t_cal_time to_calendar(logic [22:0] jdn_in, logic [26:0] frac_in);
        longint    jdn, frac, tod, t, j1, j2, j3, j4, j5, d, m, y;
        t_cal_time r;
        jdn = jdn_in;
        frac = frac_in;
        if (frac > MS_PER_DAY - 1)
            frac = MS_PER_DAY - 1;
        if (jdn >= GREGORIAN_START) begin
            t = (4 * (jdn - 1867216) - 1) / 146097;
            j1 = jdn + 1 + t - t / 4;
        end else begin
            j1 = jdn;
        end
        tod = frac + MS_HALF_DAY;
        if (tod >= MS_PER_DAY) begin
            tod -= MS_PER_DAY;
            j1 += 1;
        end
        j2 = j1 + 1524;
        j3 = (100 * j2 - 12210) / 36525;
        j4 = (1461 * j3) / 4;
        j5 = (10000 * (j2 - j4)) / 306001;
        d = j2 - j4 - (j5 * 306001) / 10000;
        m = j5 - 1;
        if (m > 12)
            m -= 12;
        y = j3 - 4715;
        if (m > 2)
            y -= 1;
        if (y <= 0)
            y -= 1;
        if (y < 0)
            y = -y;
        r.year = y[14:0];
        r.month = m[3:0];
        r.day = d[4:0];
        r.hour = 5'((tod / 3600000) & 31);
        r.minute = 6'(((tod % 3600000) / 60000) & 63);
        r.second = 6'(((tod % 60000) / 1000) & 63);
        r.milli = 10'((tod % 1000) & 1023);
        return r;
    endfunction

    function void note_request(logic [22:0] jdn, logic [26:0] frac);
        expected_q.push_back(to_calendar(jdn, frac));
        n_requests++;
    endfunction

    function void compare_field(string field, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
            n_errors++;
        end
    endfunction

    function void check_result(logic [55:0] data);
        t_cal_time want;
        n_results++;
        if (expected_q.size() == 0) begin
            $error("result with no request waiting: tdata %h", data);
            n_errors++;
            return;
        end
        want = expected_q.pop_front();
        compare_field("cal_year", want.year, data[14:0]);
        compare_field("cal_month", want.month, data[18:15]);
        compare_field("cal_day", want.day, data[23:19]);
        compare_field("hour_of_day", want.hour, data[28:24]);
        compare_field("minute_of_hour", want.minute, data[34:29]);
        compare_field("second_of_minute", want.second, data[40:35]);
        compare_field("milli_of_second", want.milli, data[50:41]);
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module julian_day_to_calendar_date_tb;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // julian_day_number [22:0], day_fraction_ms [49:23], zero fill [55:50]
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // cal_year [14:0], cal_month [18:15], cal_day [23:19], hour_of_day [28:24],
    // minute_of_hour [34:29], second_of_minute [40:35], milli_of_second [50:41]
    logic [55:0] m_axis_tdata;

    calendar_scoreboard sb;
    bit                 sender_gaps = 1'b0;
    bit                 sink_stalls = 1'b0;
    int                 stall_left = 0;
    int                 cycle_count = 0;

    julian_day_to_calendar_date dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [22:0] pick_day();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: return 23'($urandom_range(0, 8388607));
            3: return 23'($urandom_range(2299161 - 400, 2299161 + 400));
            4: return 23'($urandom_range(1721424 - 800, 1721424 + 800));
            5: return 23'($urandom_range(0, 2000));
            6: return 23'($urandom_range(8388607 - 2000, 8388607));
            default: return 23'($urandom_range(2400000, 2500000));
        endcase
    endfunction

    function automatic logic [26:0] pick_fraction();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8)
            return 27'($urandom_range(0, 86399999));
        if (r == 8) begin
            case ($urandom_range(0, 3))
                0: return 27'd0;
                1: return 27'd43199999;
                2: return 27'd43200000;
                default: return 27'd86399999;
            endcase
        end
        return 27'($urandom_range(86400000, 134217727));
    endfunction

    task automatic send_request(input logic [22:0] jdn, input logic [26:0] frac);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, frac, jdn};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The extra edge lets the monitor note a request accepted at the current edge.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata[22:0], s_axis_tdata[49:23]);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding.", sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sink_stalls = 1'b1;
        send_request(23'd0, 27'd0);
        send_request(23'd0, 27'd134217727);
        send_request(23'd8388607, 27'd86399999);
        send_request(23'd8388607, 27'd0);
        send_request(23'd2299160, 27'd43199999);
        send_request(23'd2299160, 27'd43200000);
        send_request(23'd2299161, 27'd0);
        send_request(23'd2299161, 27'd86400000);
        send_request(23'd1721057, 27'd43200000);
        send_request(23'd1721422, 27'd43199999);
        send_request(23'd1721423, 27'd43200000);
        send_request(23'd1721424, 27'd43200000);
        send_request(23'd2451544, 27'd43200000);
        send_request(23'd2451604, 27'd43200000);
        send_request(23'd2451603, 27'd86399999);
        send_request(23'd2460000, 27'd45296789);
        send_request(23'd2415020, 27'd1);
        send_request(23'd5592405, 27'd44739242);
        send_request(23'd2796202, 27'd89478485);

        wait_for_results();

        for (int blk = 0; blk < 10; blk++) begin
            sender_gaps = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
            for (int n = 0; n < 100; n++)
                send_request(pick_day(), pick_fraction());
            if (blk == 4)
                wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d date conversions of %0d requests across both calendar eras,",
                 sb.n_results, sb.n_requests);
        $display("the noon day carry, year-zero crossing and saturated day fractions.");
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending() != 0)
                $error("%0d expected results never arrived", sb.pending());
            $display("status: fail");
        end
        $finish;
    end
endmodule
